>>> sv/rhs_pkg.sv
// Package for the row hill segmenter: sizes, reset values and the payload types.
// Used by every module of the block; depends on nothing.
package rhs_pkg;

	localparam int MAX_COLS = 1024;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLS - 1);

	// The queue depth must be a power of two so that the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] THRESH_RESET = 8'd1;

	typedef struct packed {
		logic [7:0] pixel;
		logic [9:0] row_index;
		logic       end_of_row;
	} pix_item_t;

	typedef struct packed {
		logic [9:0] start_col;
		logic [9:0] end_col;
		logic [9:0] hill_row;
		logic [7:0] hill_height;
		logic       last_of_group;
	} hill_res_t;

	// All results of one pixel. A single result always travels in first.
	typedef struct packed {
		logic      two;
		hill_res_t first;
		hill_res_t second;
	} hill_grp_t;

endpackage

>>> sv/rhs_front.sv
// Front part of the row hill segmenter: accepts pixels, keeps the row state and
// the threshold register, and forms the group of results each pixel causes.
// Depends on rhs_pkg.
module rhs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rhs_pkg::pix_item_t in_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data,
	input  logic              queue_full,
	output logic              grp_push,
	output rhs_pkg::hill_grp_t grp
);
	import rhs_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_LATER  = 3'b100
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       thresh_q;
	logic [7:0]       prev_pixel_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] prev_col_q;
	logic [COL_W-1:0] start_q;
	logic [7:0]       peak_q;
	logic             rising_q;

	logic             accept;
	logic [COL_W-1:0] col_next;
	logic             rising_n;
	logic [7:0]       peak_n;
	logic [COL_W-1:0] start_n;
	logic [7:0]       flush_h;
	logic             emit_a;
	logic             emit_b;
	hill_res_t        res_a;
	hill_res_t        res_b;

	assign in_stall  = queue_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign col_next  = (col_q == COL_MAX) ? col_q : col_q + 1'b1;

	always_comb begin
		rising_n = rising_q;
		peak_n   = peak_q;
		start_n  = start_q;
		emit_a   = 1'b0;
		case (phase_q)
			PH_SECOND: begin
				rising_n = (in_item.pixel >= prev_pixel_q);
				peak_n   = (in_item.pixel > prev_pixel_q) ? in_item.pixel : prev_pixel_q;
				start_n  = prev_col_q;
			end
			PH_LATER: begin
				if (in_item.pixel >= prev_pixel_q && !rising_q) begin
					emit_a   = (peak_q > thresh_q) && (start_q != prev_col_q);
					start_n  = prev_col_q;
					peak_n   = in_item.pixel;
					rising_n = 1'b1;
				end else if (in_item.pixel <= prev_pixel_q && rising_q) begin
					peak_n   = prev_pixel_q;
					rising_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
		flush_h = (peak_n > in_item.pixel) ? peak_n : in_item.pixel;
		emit_b  = in_item.end_of_row && (phase_q != PH_FIRST) && (flush_h > thresh_q);

		res_a.start_col     = 10'(start_q);
		res_a.end_col       = 10'(prev_col_q);
		res_a.hill_row      = in_item.row_index;
		res_a.hill_height   = peak_q;
		res_a.last_of_group = !emit_b;

		res_b.start_col     = 10'(start_n);
		res_b.end_col       = 10'(col_q);
		res_b.hill_row      = in_item.row_index;
		res_b.hill_height   = flush_h;
		res_b.last_of_group = 1'b1;

		grp.two    = emit_a && emit_b;
		grp.first  = emit_a ? res_a : res_b;
		grp.second = res_b;
	end

	assign grp_push = accept && (emit_a || emit_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			prev_pixel_q <= '0;
			col_q        <= '0;
			prev_col_q   <= '0;
			start_q      <= '0;
			peak_q       <= '0;
			rising_q     <= 1'b0;
		end else if (accept) begin
			prev_pixel_q <= in_item.pixel;
			prev_col_q   <= col_q;
			rising_q     <= rising_n;
			peak_q       <= peak_n;
			start_q      <= start_n;
			if (in_item.end_of_row) begin
				col_q   <= '0;
				phase_q <= PH_FIRST;
			end else begin
				col_q   <= col_next;
				phase_q <= (phase_q == PH_FIRST) ? PH_SECOND : PH_LATER;
			end
		end
	end

endmodule

>>> sv/rhs_queue.sv
// Short queue of result groups between the front and back parts of the segmenter.
// Depends on rhs_pkg.
module rhs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rhs_pkg::hill_grp_t wr_grp,
	input  logic               pop,
	output rhs_pkg::hill_grp_t head,
	output logic               head_valid,
	output logic               full
);
	import rhs_pkg::*;

	hill_grp_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("Queue written while full.");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("Queue read while empty.");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("Queue count out of range.");

endmodule

>>> sv/rhs_back.sv
// Back part of the segmenter: takes result groups from the queue and delivers
// them one transaction at a time through the output register. Depends on rhs_pkg.
module rhs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rhs_pkg::hill_grp_t head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output rhs_pkg::hill_res_t out_item
);
	import rhs_pkg::*;

	logic      out_valid_q;
	hill_res_t out_q;
	logic      half_q;
	logic      load;

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && head_valid && (half_q || !head.two);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= half_q ? head.second : head.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				half_q <= !half_q && head.two;
			end
		end
	end

	a_half_has_pair: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> head_valid && head.two) else $error("Second result pending without a pair.");
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(half_q) |-> out_valid_q && !out_q.last_of_group)
		else $error("First result of a pair marked last.");
	a_pop_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && out_q.last_of_group) else $error("Group popped before its last result.");

endmodule

>>> sv/row_hill_segmenter_top.sv
// Top level of the row hill segmenter: front, result queue and back part.
// Depends on rhs_pkg, rhs_front, rhs_queue and rhs_back.
//
// Pixels of a row enter one per transaction and may come in every cycle while
// in_stall is low. Each pixel updates the row state in the cycle it is accepted;
// a pixel that closes a hill or ends a row may put one or two results, as one
// group, into a four-entry queue; they pass the queue and output register and
// leave one per cycle while out_stall is low. in_stall rises only while the queue
// is full. The threshold is written through the cfg port, which is always ready;
// the user must write it only while the block is idle; nothing enforces that.
module row_hill_segmenter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rhs_pkg::pix_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output rhs_pkg::hill_res_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import rhs_pkg::*;

	hill_grp_t grp;
	hill_grp_t head;
	logic      grp_push;
	logic      queue_full;
	logic      head_valid;
	logic      pop;

	rhs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.grp_push   (grp_push),
		.grp        (grp)
	);

	rhs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (grp_push),
		.wr_grp     (grp),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (queue_full)
	);

	rhs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule
